// ----- rtl/u2e_pkg.sv -----
// u2e_pkg: shared types, constants and helpers for the utf-8 to unicode escape block
// no dependencies; imported by the decoder, the serializer and the top level

package u2e_pkg;

  // escape text layout
  localparam int unsigned EscLen  = 6;
  localparam int unsigned PairLen = 12;
  localparam int unsigned IdxW    = 4;

  localparam logic [6:0] CharBslash = 7'h5C;
  localparam logic [6:0] CharU      = 7'h75;
  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharLowA   = 7'h61;

  // surrogate bases and offset
  localparam logic [15:0] HiSurBase  = 16'hD800;
  localparam logic [5:0]  LoSurTop   = 6'b110111;
  localparam logic [20:0] SupplBase  = 21'h010000;
  localparam logic [20:0] BmpMax     = 21'h00FFFF;

  // one or two utf-16 units waiting to be written out
  typedef struct packed {
    logic [15:0] hi;
    logic [15:0] lo;
    logic        pair;
  } unit_pair_t;

  // handoff between decoder and serializer
  typedef struct packed {
    logic       valid;
    unit_pair_t units;
  } pend_t;

  // lower-case hex digit for one nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = CharZero + {3'b000, nib};
    end else begin
      c = CharLowA + {3'b000, nib} - 7'd10;
    end
    return c;
  endfunction

endpackage

// ----- rtl/u2e_if.sv -----
// u2e_byte_if and u2e_char_if: valid/ready channels for input bytes and escape chars
// no dependencies

interface u2e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/u2e_decoder.sv -----
// u2e_decoder: utf-8 gather state and surrogate split into a one-deep pending register
// depends on u2e_pkg and u2e_byte_if

module u2e_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  u2e_byte_if.sink       in_i,
  input  logic           pend_take_i,
  output u2e_pkg::pend_t pend_o
);
  import u2e_pkg::*;

  logic [20:0] pcp_q, pcp_d;
  logic [1:0]  rem_q, rem_d;
  logic        pend_valid_q, pend_valid_d;
  unit_pair_t  pend_units_q, pend_units_d;

  logic        emit;
  logic [20:0] cp;
  logic [20:0] v;
  logic [7:0]  b;
  logic        accept;
  unit_pair_t  units;

  assign b      = in_i.in_byte;
  assign in_i.ready = !pend_valid_q || pend_take_i;
  assign accept = in_i.valid && in_i.ready;

  // byte classification and gather state update
  always_comb begin
    pcp_d = pcp_q;
    rem_d = rem_q;
    emit  = 1'b0;
    cp    = {13'd0, b};
    if (b[7:6] == 2'b10) begin
      if (rem_q != 2'd0) begin
        cp    = {pcp_q[14:0], b[5:0]};
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          emit  = 1'b1;
          pcp_d = '0;
        end else begin
          pcp_d = cp;
        end
      end else begin
        emit = 1'b1;
      end
    end else begin
      // any non-continuation byte drops a partial sequence
      pcp_d = '0;
      rem_d = 2'd0;
      if (b[7] == 1'b0) begin
        emit = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        pcp_d = {16'd0, b[4:0]};
        rem_d = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        pcp_d = {17'd0, b[3:0]};
        rem_d = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        pcp_d = {18'd0, b[2:0]};
        rem_d = 2'd3;
      end else begin
        emit = 1'b1;
      end
    end
  end

  // split into utf-16 units
  always_comb begin
    v = cp - SupplBase;
    if (cp > BmpMax) begin
      units.hi   = HiSurBase + {5'd0, v[20:10]};
      units.lo   = {LoSurTop, v[9:0]};
      units.pair = 1'b1;
    end else begin
      units.hi   = cp[15:0];
      units.lo   = cp[15:0];
      units.pair = 1'b0;
    end
  end

  // pending register next value
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_units_d = pend_units_q;
    if (pend_take_i) begin
      pend_valid_d = 1'b0;
    end
    if (accept && emit) begin
      pend_valid_d = 1'b1;
      pend_units_d = units;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q        <= '0;
      rem_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        pcp_q <= pcp_d;
        rem_q <= rem_d;
      end
    end
  end

  // pending payload
  always_ff @(posedge clk_i) begin
    pend_units_q <= pend_units_d;
  end

  assign pend_o.valid = pend_valid_q;
  assign pend_o.units = pend_units_q;

endmodule

// ----- rtl/u2e_serializer.sv -----
// u2e_serializer: writes each pending unit pair out as escape text, one char per word
// depends on u2e_pkg and u2e_char_if

module u2e_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  u2e_pkg::pend_t pend_i,
  output logic           pend_take_o,
  u2e_char_if.source     out_o
);
  import u2e_pkg::*;

  logic            act_valid_q, act_valid_d;
  unit_pair_t      act_q, act_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [6:0]      out_char_q, out_char_d;
  logic            out_last_q, out_last_d;

  logic            advance;
  logic            final_char;
  logic [IdxW-1:0] pos;
  logic [15:0]     unit;
  logic [6:0]      chr;

  assign advance    = act_valid_q && (!out_valid_q || out_o.ready);
  assign final_char = act_q.pair ? (idx_q == IdxW'(PairLen - 1)) : (idx_q == IdxW'(EscLen - 1));
  assign pend_take_o = pend_i.valid && (!act_valid_q || (advance && final_char));

  // character at the current index
  always_comb begin
    if (idx_q >= IdxW'(EscLen)) begin
      pos  = idx_q - IdxW'(EscLen);
      unit = act_q.lo;
    end else begin
      pos  = idx_q;
      unit = act_q.hi;
    end
    case (pos[2:0])
      3'd0:    chr = CharBslash;
      3'd1:    chr = CharU;
      3'd2:    chr = hex_char(unit[15:12]);
      3'd3:    chr = hex_char(unit[11:8]);
      3'd4:    chr = hex_char(unit[7:4]);
      3'd5:    chr = hex_char(unit[3:0]);
      default: chr = CharBslash;
    endcase
  end

  // active descriptor and index
  always_comb begin
    act_valid_d = act_valid_q;
    act_d       = act_q;
    idx_d       = idx_q;
    if (advance) begin
      idx_d = idx_q + IdxW'(1);
      if (final_char) begin
        act_valid_d = 1'b0;
      end
    end
    if (pend_take_o) begin
      act_valid_d = 1'b1;
      act_d       = pend_i.units;
      idx_d       = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      out_char_d  = chr;
      out_last_d  = final_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      act_valid_q <= act_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.last_char = out_last_q;

endmodule

// ----- rtl/utf8_to_unicode_escape.sv -----
// utf8_to_unicode_escape: top level, decoder feeding the escape serializer
// depends on u2e_pkg, u2e_if, u2e_decoder and u2e_serializer

// Takes UTF-8 text one byte per word on in_i and gives its \uXXXX escape
// text on out_o, one ASCII char per word, with last_char set on the final
// hex digit of each code point. Code points above 0xFFFF come out as a
// high/low surrogate pair (twelve chars), bytes that cannot start or
// continue a sequence come out as the escape of their own value, and a lead
// byte arriving mid-sequence drops the partial code point. A byte that
// only gathers bits produces no output; a byte that completes a code point
// is written out as six chars (twelve for a surrogate pair) by the
// serializer, one char per cycle while the output is not stalled. One
// completed code point can wait in a pending register while the previous
// one is written out, so input stalls only when both are occupied. The
// completing byte passes the pending, active and output registers in turn.

module utf8_to_unicode_escape (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2e_byte_if.sink   in_i,
  u2e_char_if.source out_o
);
  import u2e_pkg::*;

  pend_t pend;
  logic  pend_take;

  // byte decode and pending register
  u2e_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pend_take_i (pend_take),
    .pend_o      (pend)
  );

  // escape text output
  u2e_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pend_i      (pend),
    .pend_take_o (pend_take),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/u2e_checker.sv -----
// u2e_checker: port-level assertions on the escape output, bound to the top level
// depends on utf8_to_unicode_escape ports only

module u2e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       out_last_i
);

  logic is_hex;
  assign is_hex = ((out_char_i >= 7'h30) && (out_char_i <= 7'h39)) ||
                  ((out_char_i >= 7'h61) && (out_char_i <= 7'h66));

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // only escape characters appear
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i == 7'h5C) || (out_char_i == 7'h75) || is_hex)
    else $error("output char outside escape alphabet");

  // backslash is followed straight away by u
  a_bslash_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (out_char_i == 7'h5C) |=> out_valid_i && (out_char_i == 7'h75))
    else $error("backslash not followed by u");

  // last flag only on a hex digit
  a_last_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> is_hex)
    else $error("last flag on a non-digit char");

endmodule

bind utf8_to_unicode_escape u2e_checker u_u2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_last_i  (out_o.last_char)
);

// ----- tb/tb_utf8_to_unicode_escape.sv -----
`timescale 1ns / 100ps
// tb_utf8_to_unicode_escape: self-checking bench that feeds utf-8 bytes and checks the escape text
// depends on u2e_pkg, u2e_if and the utf8_to_unicode_escape rtl

import u2e_pkg::*;

// one character of escape text as it should appear on the output
typedef struct packed {
  logic [6:0] ch;
  logic       last;
} esc_char_t;

// decodes accepted bytes and holds the escape chars still owed by the block
class escape_scoreboard;
  localparam logic [15:0] LoSurBase = 16'hDC00;
  localparam string HexDigits = "0123456789abcdef";

  logic [20:0] partial_cp;
  logic [1:0]  owed;
  esc_char_t   expected_chars[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned code_points;

  function new();
    partial_cp  = '0;
    owed        = '0;
    errors      = 0;
    checked     = 0;
    code_points = 0;
  endfunction

  function int unsigned pending();
    return expected_chars.size();
  endfunction

  // backslash, u, then four lower-case hex digits of one utf-16 unit
  function void push_escape(logic [15:0] unit, logic final_unit);
    esc_char_t c;
    c.ch = CharBslash; c.last = 1'b0; expected_chars.push_back(c);
    c.ch = CharU;      c.last = 1'b0; expected_chars.push_back(c);
    for (int k = 0; k < 4; k++) begin
      c.ch   = 7'(HexDigits[unit[15 - 4*k -: 4]]);
      c.last = final_unit && (k == 3);
      expected_chars.push_back(c);
    end
  endfunction

  // code points above the bmp split into a surrogate pair
  function void push_code_point(logic [20:0] cp);
    logic [20:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    code_points++;
    if (cp > BmpMax) begin
      v  = cp - SupplBase;
      hi = HiSurBase + 16'(v[20:10]);
      lo = LoSurBase + 16'(v[9:0]);
      push_escape(hi, 1'b0);
      push_escape(lo, 1'b1);
    end else begin
      push_escape(cp[15:0], 1'b1);
    end
  endfunction

  // decoder step for one accepted byte
  function void note_byte(logic [7:0] b);
    if (b[7:6] == 2'b10) begin
      if (owed != 2'd0) begin
        partial_cp = {partial_cp[14:0], b[5:0]};
        owed       = owed - 2'd1;
        if (owed == 2'd0) begin
          push_code_point(partial_cp);
          partial_cp = '0;
        end
      end else begin
        // continuation with nothing owed
        push_code_point({13'd0, b});
      end
    end else begin
      // any non-continuation byte drops a partial sequence
      partial_cp = '0;
      owed       = '0;
      if (!b[7]) begin
        push_code_point({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
        partial_cp = {16'd0, b[4:0]};
        owed       = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial_cp = {17'd0, b[3:0]};
        owed       = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial_cp = {18'd0, b[2:0]};
        owed       = 2'd3;
      end else begin
        push_code_point({13'd0, b});
      end
    end
  endfunction

  // compare one output word with the oldest expected char
  function void check_char(logic [6:0] ch, logic last);
    esc_char_t exp_c;
    checked++;
    if (expected_chars.size() == 0) begin
      errors++;
      $display("%0t: unexpected char: expected none, actual ch=%h last=%b", $time, ch, last);
      return;
    end
    exp_c = expected_chars.pop_front();
    if (ch !== exp_c.ch) begin
      errors++;
      $display("%0t: out_char mismatch: expected %h, actual %h", $time, exp_c.ch, ch);
    end
    if (last !== exp_c.last) begin
      errors++;
      $display("%0t: last_char mismatch: expected %b, actual %b", $time, exp_c.last, last);
    end
  endfunction
endclass

module tb_utf8_to_unicode_escape;

  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned BytesPerPhase  = 80;
  localparam int unsigned NumPhases      = 4;

  logic clk_i;
  logic rst_ni;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;

  escape_scoreboard sb;

  u2e_byte_if byte_ch ();
  u2e_char_if char_ch ();

  utf8_to_unicode_escape dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (char_ch)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // present one byte, with random idle cycles ahead of it, and wait for the handshake
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // lead byte plus a given number of continuation bytes, random payload bits
  task automatic send_sequence(input int unsigned len, input int unsigned conts);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1: send_byte({1'b0, r[6:0]});
      2: send_byte({3'b110, r[4:0]});
      3: send_byte({4'b1110, r[3:0]});
      default: send_byte({5'b11110, r[2:0]});
    endcase
    for (int i = 0; i < conts; i++) begin
      r = 8'($urandom);
      send_byte({2'b10, r[5:0]});
    end
  endtask

  // receiver: random stall, check every accepted char
  always @(posedge clk_i) begin
    if (rst_ni && char_ch.valid && char_ch.ready) begin
      sb.check_char(char_ch.out_char, char_ch.last_char);
    end
    char_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d chars still expected", $time, sb.pending());
        $display("** utf8_to_unicode_escape: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] directed_bytes[$];
    int unsigned kind;
    int unsigned len;
    logic [7:0] r;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    char_ch.ready   = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    bytes_sent      = 0;
    quiet_cycles    = 0;
    sb = new();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ascii extremes, invalid bytes, overlong, three-byte, encoded surrogate,
    // four-byte, largest four-byte value, stray leads mid-sequence
    directed_bytes = '{8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
                       8'hC0, 8'h80,
                       8'hE2, 8'h82, 8'hAC,
                       8'hED, 8'hA0, 8'h80,
                       8'hF0, 8'h9F, 8'h98, 8'h80,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF,
                       8'hE2, 8'hC3, 8'hA9,
                       8'hF0, 8'h41};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // random: mostly well-formed sequences, some truncated ones and raw noise
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      while (bytes_sent < 26 + (phase + 1) * BytesPerPhase) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          len = $urandom_range(1, 4);
          send_sequence(len, len - 1);
        end else if (kind < 85) begin
          len = $urandom_range(2, 4);
          send_sequence(len, $urandom_range(0, len - 2));
        end else begin
          r = 8'($urandom);
          send_byte(r);
        end
      end
    end
    byte_ch.valid <= 1'b0;

    // let the block drain, then a few more cycles for stray output
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d bytes decoded into %0d code points, %0d chars checked",
             bytes_sent, sb.code_points, sb.checked);
    $display("idle mixes: none, sender only, receiver only, both; %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("** utf8_to_unicode_escape: PASSED **");
    end else begin
      $display("** utf8_to_unicode_escape: FAILED **");
    end
    $finish;
  end

endmodule
